@@ sv/gha_pkg.sv @@
// Shared types and codes for the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

    // Request operation codes
    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  handle_slot;
        logic [31:0] handle_generation;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  result_slot;
        logic [31:0] result_generation;
    } rsp_t;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

@@ sv/gha_ram.sv @@
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module gha_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 33
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/generational_handle_allocator.sv @@
// Top level of the generational handle allocator.
`timescale 1ns / 1ps

// Generational handle table. When a request is accepted, the slot table
// (occupancy and generation) and the free stack are read from synchronous
// RAMs; in S_EXEC, once the response register is free, the handle is checked,
// the result is loaded into the response register and the RAMs are written
// back; no request is taken during S_EXEC. A new request may be accepted while
// a previous response still waits on rsp_stall. Freed slots are pushed with
// their new generation, so a create never needs a second table read. Slots at
// or above the high-water mark count as never used, so no clearing pass runs
// after reset and requests are taken at once. Slot zero is never handed out.
module generational_handle_allocator #(
    parameter int SLOT_COUNT = 256,
    parameter int GEN_BITS   = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  gha_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output gha_pkg::rsp_t rsp
);

    import gha_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NW = $clog2(SLOT_COUNT + 1);
    localparam int CW = (NW > 8) ? NW : 8;

    state_t               state_reg, state_next;
    logic [NW-1:0]        free_count_reg, free_count_next;
    logic [NW-1:0]        next_fresh_reg, next_fresh_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;
    req_t                 item_reg;

    logic                 accept;
    logic                 out_free;
    logic [NW-1:0]        pop_idx;

    logic                 gen_we;
    logic [SW-1:0]        gen_waddr;
    logic [GEN_BITS:0]    gen_wdata;
    logic [GEN_BITS:0]    gen_rdata;
    logic                 stk_we;
    logic [SW+GEN_BITS-1:0] stk_wdata;
    logic [SW+GEN_BITS-1:0] stk_rdata;

    logic                 rd_occ;
    logic [GEN_BITS-1:0]  rd_gen;
    logic [GEN_BITS-1:0]  inc_gen;
    logic [GEN_BITS-1:0]  new_gen;
    logic [SW-1:0]        item_slot;
    logic                 handle_ok;
    logic [SW-1:0]        pop_slot;
    logic [GEN_BITS-1:0]  pop_gen;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign pop_idx   = free_count_reg - NW'(1);
    assign item_slot = SW'(item_reg.handle_slot);

    // Slot table: {occupied, generation} per slot
    gha_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (SW),
        .DW    (GEN_BITS + 1)
    ) u_slot_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (accept),
        .raddr (SW'(req.handle_slot)),
        .rdata (gen_rdata)
    );

    // Free stack: {slot, generation} per freed slot
    gha_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (SW),
        .DW    (SW + GEN_BITS)
    ) u_free_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (free_count_reg[SW-1:0]),
        .wdata (stk_wdata),
        .re    (accept),
        .raddr (pop_idx[SW-1:0]),
        .rdata (stk_rdata)
    );

    // Split read data and check the handle
    assign rd_occ    = gen_rdata[GEN_BITS];
    assign rd_gen    = gen_rdata[GEN_BITS-1:0];
    assign pop_slot  = stk_rdata[SW+GEN_BITS-1:GEN_BITS];
    assign pop_gen   = stk_rdata[GEN_BITS-1:0];
    assign inc_gen   = rd_gen + GEN_BITS'(1);
    assign new_gen   = (inc_gen == '0) ? GEN_BITS'(1) : inc_gen;
    assign handle_ok = (CW'(item_reg.handle_slot) != '0)
                    && (CW'(item_reg.handle_slot) < CW'(next_fresh_reg))
                    && rd_occ
                    && (item_reg.handle_generation == 32'(rd_gen));

    assign stk_wdata = {item_slot, new_gen};

    // Sequence the request and write back the tables
    always_comb
    begin
        state_next      = state_reg;
        free_count_next = free_count_reg;
        next_fresh_next = next_fresh_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        gen_we          = 1'b0;
        gen_waddr       = item_slot;
        gen_wdata       = {1'b0, new_gen};
        stk_we          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next.status            = ST_INVALID;
                    rsp_next.result_slot       = item_reg.handle_slot;
                    rsp_next.result_generation = '0;
                    case (item_reg.opcode)
                        OP_CREATE:
                        begin
                            if (free_count_reg != '0)
                            begin
                                // Reuse the most recently freed slot
                                free_count_next = pop_idx;
                                gen_we    = 1'b1;
                                gen_waddr = pop_slot;
                                gen_wdata = {1'b1, pop_gen};
                                rsp_next.status            = ST_OK;
                                rsp_next.result_slot       = 8'(pop_slot);
                                rsp_next.result_generation = 32'(pop_gen);
                            end
                            else if (next_fresh_reg < NW'(SLOT_COUNT))
                            begin
                                // Advance the high-water mark
                                next_fresh_next = next_fresh_reg + NW'(1);
                                gen_we    = 1'b1;
                                gen_waddr = next_fresh_reg[SW-1:0];
                                gen_wdata = {1'b1, GEN_BITS'(1)};
                                rsp_next.status            = ST_OK;
                                rsp_next.result_slot       = 8'(next_fresh_reg);
                                rsp_next.result_generation = 32'd1;
                            end
                            else
                            begin
                                rsp_next.status      = ST_FULL;
                                rsp_next.result_slot = '0;
                            end
                        end
                        OP_DESTROY:
                        begin
                            if (handle_ok)
                            begin
                                // Free the slot and bump its generation
                                gen_we = 1'b1;
                                if (free_count_reg < NW'(SLOT_COUNT))
                                begin
                                    stk_we          = 1'b1;
                                    free_count_next = free_count_reg + NW'(1);
                                end
                                rsp_next.status            = ST_OK;
                                rsp_next.result_generation = 32'(rd_gen);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (handle_ok)
                            begin
                                rsp_next.status            = ST_OK;
                                rsp_next.result_generation = 32'(rd_gen);
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ST_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            next_fresh_reg <= NW'(1);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            next_fresh_reg <= next_fresh_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers: hold the request, load the response
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ sv/gha_checker.sv @@
// Port-level checks for the generational handle allocator, bound to the top.
`timescale 1ns / 1ps

module gha_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input gha_pkg::rsp_t rsp
);

    import gha_pkg::*;

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // A full table reports no slot and no generation
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |->
            (rsp.result_slot == 8'd0) && (rsp.result_generation == 32'd0))
        else $error("full response carries a handle");

    // A rejected handle reports generation zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_INVALID) |-> (rsp.result_generation == 32'd0))
        else $error("invalid response carries a generation");

    // A successful transfer never shows generation zero
    a_ok_gen: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_OK) |-> (rsp.result_generation != 32'd0))
        else $error("ok response with generation zero");

    // An accepted request stalls the next cycle while it executes
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted back to back");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);

@@ dv/generational_handle_allocator_tb.sv @@
// Self-checking testbench for the generational handle allocator.
`timescale 1ns / 1ps

module generational_handle_allocator_tb;

    import gha_pkg::*;

    localparam int SLOTS      = 256;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_SPAN  = 100;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // Tracks the handle table and keeps the responses it predicts, oldest first.
    class handle_table_model;
        logic [31:0] gen_of [SLOTS];
        bit          occupied [SLOTS];
        logic [7:0]  recycled [SLOTS];
        int unsigned free_top;
        int unsigned high_water;
        int          live_slots [$];
        rsp_t        expected_rsps [$];
        int          errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                gen_of[i]   = 32'd1;
                occupied[i] = 1'b0;
                recycled[i] = 8'd0;
            end
            free_top   = 0;
            high_water = 1;
            errors     = 0;
        endfunction

        function bit handle_live(int s, logic [31:0] g);
            return s != 0 && s < high_water && occupied[s] && gen_of[s] == g;
        endfunction

        function rsp_t predict_response(req_t r);
            rsp_t        o;
            int          s;
            int          hits [$];
            logic [31:0] ng;
            o.status            = ST_INVALID;
            o.result_slot       = r.handle_slot;
            o.result_generation = '0;
            s = r.handle_slot;
            case (r.opcode)
                OP_CREATE:
                begin
                    // pop the most recent free slot, else take a fresh one
                    if (free_top > 0)
                    begin
                        free_top--;
                        s = recycled[free_top];
                    end
                    else if (high_water < SLOTS)
                    begin
                        s = high_water;
                        high_water++;
                    end
                    else
                    begin
                        o.status      = ST_FULL;
                        o.result_slot = '0;
                        return o;
                    end
                    occupied[s] = 1'b1;
                    live_slots.insert(live_slots.size(), s);
                    o.status            = ST_OK;
                    o.result_slot       = s[7:0];
                    o.result_generation = gen_of[s];
                end
                OP_DESTROY:
                begin
                    if (handle_live(s, r.handle_generation))
                    begin
                        o.status            = ST_OK;
                        o.result_generation = gen_of[s];
                        occupied[s] = 1'b0;
                        ng = gen_of[s] + 32'd1;
                        gen_of[s] = (ng == 32'd0) ? 32'd1 : ng;
                        if (free_top < SLOTS)
                        begin
                            recycled[free_top] = s[7:0];
                            free_top++;
                        end
                        hits = live_slots.find_first_index(x) with (x == s);
                        if (hits.size() > 0)
                            live_slots.delete(hits[0]);
                    end
                end
                OP_LOOKUP:
                begin
                    if (handle_live(s, r.handle_generation))
                    begin
                        o.status            = ST_OK;
                        o.result_generation = gen_of[s];
                    end
                end
                default:
                begin
                end
            endcase
            return o;
        endfunction

        function void note_request(req_t r);
            expected_rsps.insert(expected_rsps.size(), predict_response(r));
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                $error("response with nothing pending: status %0d slot %0d gen %0h",
                       got.status, got.result_slot, got.result_generation);
                errors++;
                return;
            end
            want = expected_rsps.pop_front();
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.result_slot !== want.result_slot)
            begin
                $error("result_slot mismatch: expected %0d, got %0d",
                       want.result_slot, got.result_slot);
                errors++;
            end
            if (got.result_generation !== want.result_generation)
            begin
                $error("result_generation mismatch: expected %0h, got %0h",
                       want.result_generation, got.result_generation);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    handle_table_model book;
    bit no_idle;
    bit hold_rsp;

    generational_handle_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic req_t make_req(logic [1:0] op, logic [7:0] s, logic [31:0] g);
        req_t r;
        r.opcode            = op;
        r.handle_slot       = s;
        r.handle_generation = g;
        return r;
    endfunction

    // Mostly real handles from the live set, some corrupted, the rest noise.
    function automatic req_t random_request(int create_pct);
        req_t r;
        int   pick;
        int   live_n;
        int   s;
        r.opcode            = OP_CREATE;
        r.handle_slot       = 8'($urandom_range(0, 255));
        r.handle_generation = $urandom();
        live_n = book.live_slots.size();
        if ($urandom_range(0, 99) < create_pct)
            return r;
        pick = $urandom_range(0, 99);
        if (live_n > 0 && pick < 75)
        begin
            s = book.live_slots[$urandom_range(0, live_n - 1)];
            r.handle_slot       = s[7:0];
            r.handle_generation = book.gen_of[s];
            r.opcode            = (pick < 40) ? OP_DESTROY : OP_LOOKUP;
            // flip one generation bit to make a stale handle
            if (pick >= 62)
                r.handle_generation ^= 32'd1 << $urandom_range(0, 31);
            return r;
        end
        if (pick < 95)
        begin
            r.opcode = $urandom_range(0, 1) ? OP_DESTROY : OP_LOOKUP;
            if ($urandom_range(0, 1))
                r.handle_generation = $urandom_range(1, 4);
            return r;
        end
        r.opcode = OP_UNKNOWN;
        return r;
    endfunction

    // Offer one request after a random gap and hold it until the transfer.
    task automatic send_request(input req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        book.note_request(r);
    endtask

    // Stop offering until every predicted response has come back.
    task automatic drain_responses();
        req_valid <= 1'b0;
        do @(posedge clk); while (book.pending() != 0);
    endtask

    // Response side: random stalls, quiet stretches and one long hold-off.
    initial
    begin : receiver
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_SPAN) @(posedge clk);
                hold_rsp = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
        end
    end

    // Check every response transfer.
    initial
    begin : monitor
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                book.check_response(rsp);
        end
    end

    // End the run when no transfer happens for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle = 0;
            else
                idle++;
        end
        $display("FAIL generational_handle_allocator");
        $finish;
    end

    initial
    begin : main
        int seg_pct [4];
        int seg_len [4];
        book      = new();
        no_idle   = 1'b0;
        hold_rsp  = 1'b0;
        seg_pct   = '{15, 40, 70, 35};
        seg_len   = '{250, 200, 200, 40};
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_stall <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: slot zero, high-water bound, stale and wrong generations, reuse
        send_request(make_req(OP_LOOKUP, 8'd0, 32'd1));
        send_request(make_req(OP_LOOKUP, 8'd1, 32'd1));
        send_request(make_req(OP_CREATE, 8'd0, 32'd0));
        send_request(make_req(OP_CREATE, 8'hff, 32'hffff_ffff));
        send_request(make_req(OP_LOOKUP, 8'd1, 32'd1));
        send_request(make_req(OP_LOOKUP, 8'd1, 32'd0));
        send_request(make_req(OP_LOOKUP, 8'd1, 32'hffff_ffff));
        send_request(make_req(OP_LOOKUP, 8'd255, 32'd1));
        send_request(make_req(OP_DESTROY, 8'd2, 32'd2));
        send_request(make_req(OP_DESTROY, 8'd2, 32'd1));
        send_request(make_req(OP_DESTROY, 8'd2, 32'd1));
        send_request(make_req(OP_LOOKUP, 8'd2, 32'd2));
        send_request(make_req(OP_DESTROY, 8'd1, 32'd1));
        send_request(make_req(OP_CREATE, 8'd0, 32'd0));
        send_request(make_req(OP_CREATE, 8'd0, 32'd0));
        send_request(make_req(OP_CREATE, 8'd0, 32'd0));
        send_request(make_req(OP_UNKNOWN, 8'd3, 32'd1));
        send_request(make_req(OP_UNKNOWN, 8'd255, 32'hffff_ffff));
        send_request(make_req(OP_DESTROY, 8'd0, 32'd1));
        send_request(make_req(OP_LOOKUP, 8'd2, 32'd2));
        send_request(make_req(OP_LOOKUP, 8'd3, 32'd1));
        drain_responses();

        // fill the table back to back while the response side holds off
        hold_rsp = 1'b1;
        no_idle  = 1'b1;
        while (!(book.high_water == SLOTS && book.free_top == 0))
            send_request(make_req(OP_CREATE, 8'($urandom_range(0, 255)), $urandom()));
        repeat (4) send_request(make_req(OP_CREATE, 8'($urandom_range(0, 255)), $urandom()));
        no_idle = 1'b0;
        drain_responses();

        // random traffic in segments with create shares of 15, 40, 70 and 35 percent
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < seg_len[k]; i++)
            begin
                no_idle = (i % 100) >= 80;
                send_request(random_request(seg_pct[k]));
            end
            no_idle = 1'b0;
            drain_responses();
        end

        repeat (10) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("PASS generational_handle_allocator");
        else
            $display("FAIL generational_handle_allocator");
        $finish;
    end

endmodule
